[design/gcd_pkg.sv]
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types, widths and constants for the great circle distance core.
// ----------------------------------------------------------------------------
package gcd_pkg;

   // payload field widths
   localparam int LATW  = 24;
   localparam int LONW  = 25;
   localparam int DISTW = 22;

   // CORDIC step count
   localparam int STEPS = 24;

   // angle in 2^-24 degree, Q30 datapath, products, sqrt
   typedef logic signed [34:0] ang_type;
   typedef logic signed [33:0] xy_type;
   typedef logic signed [31:0] q_type;
   typedef logic signed [63:0] prod_type;
   typedef logic        [60:0] rem_type;
   typedef logic        [61:0] trial_type;
   typedef logic        [30:0] root_type;
   typedef logic        [31:0] zc_type;
   typedef logic        [35:0] t_type;
   typedef logic        [36:0] tr_type;

   localparam int ROOTW = 31;

   localparam ang_type ANG_FULL    = 35'sd6039797760;
   localparam ang_type ANG_HALF    = 35'sd3019898880;
   localparam ang_type ANG_QUARTER = 35'sd1509949440;

   localparam xy_type   CORDIC_X0 = 34'sd652032874;
   localparam q_type    Q30_ONE   = 32'sd1073741824;
   localparam prod_type Q30_HALF  = 64'sd536870912;
   localparam rem_type  Q60_ONE   = 61'h1000_0000_0000_0000;
   localparam tr_type   OUT_RND   = 37'd8192;

   // atan(2^-i) in 2^-24 degree
   localparam ang_type ATAN_TAB [STEPS] = '{
      35'sd754974720, 35'sd445687602, 35'sd235489088, 35'sd119537938,
      35'sd60000934,  35'sd30029717,  35'sd15018523,  35'sd7509720,
      35'sd3754917,   35'sd1877466,   35'sd938734,    35'sd469367,
      35'sd234684,    35'sd117342,    35'sd58671,     35'sd29335,
      35'sd14668,     35'sd7334,      35'sd3667,      35'sd1833,
      35'sd917,       35'sd458,       35'sd229,       35'sd115
   };

endpackage

[design/gcd_req_if.sv]
// ----------------------------------------------------------------------------
// gcd_req_if
// Request channel: two points, latitude and longitude, valid/ready.
// ----------------------------------------------------------------------------
interface gcd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [gcd_pkg::LATW-1:0]     lat_a;
   logic signed [gcd_pkg::LONW-1:0]     lon_a;
   logic signed [gcd_pkg::LATW-1:0]     lat_b;
   logic signed [gcd_pkg::LONW-1:0]     lon_b;

   modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
   modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

[design/gcd_rsp_if.sv]
// ----------------------------------------------------------------------------
// gcd_rsp_if
// Response channel: distance in NM * 256, valid/ready.
// ----------------------------------------------------------------------------
interface gcd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gcd_pkg::DISTW-1:0]   distance_nm;

   modport source (output valid, distance_nm, input ready);
   modport sink   (input valid, distance_nm, output ready);
endinterface

[design/gcd_rotate.sv]
// ----------------------------------------------------------------------------
// gcd_rotate
// Sine/cosine by pipelined rotation CORDIC, one step per stage.
// Pipeline: range fold, 24 steps, sign fix.
// ----------------------------------------------------------------------------
module gcd_rotate (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             vld_i,
   input  gcd_pkg::ang_type ang_i,
   output logic             vld_o,
   output gcd_pkg::q_type   sin_o,
   output gcd_pkg::q_type   cos_o
);

   localparam int N = gcd_pkg::STEPS;

   gcd_pkg::ang_type red;
   gcd_pkg::ang_type fold_in;
   logic             neg_in;

   logic             vld_ff [0:N+1];
   logic             neg_ff [0:N];
   gcd_pkg::ang_type z_ff   [0:N];
   gcd_pkg::xy_type  x_ff   [1:N];
   gcd_pkg::xy_type  y_ff   [1:N];
   gcd_pkg::xy_type  x_st   [0:N];
   gcd_pkg::xy_type  y_st   [0:N];
   gcd_pkg::q_type   sin_ff, cos_ff;

   // reduce to [-180, 180) then fold into [-90, 90]
   always_comb begin
      if (ang_i >= gcd_pkg::ANG_HALF) begin
         red = ang_i - gcd_pkg::ANG_FULL;
      end else if (ang_i < -gcd_pkg::ANG_HALF) begin
         red = ang_i + gcd_pkg::ANG_FULL;
      end else begin
         red = ang_i;
      end
      neg_in = 1'b1;
      if (red > gcd_pkg::ANG_QUARTER) begin
         fold_in = red - gcd_pkg::ANG_HALF;
      end else if (red < -gcd_pkg::ANG_QUARTER) begin
         fold_in = red + gcd_pkg::ANG_HALF;
      end else begin
         fold_in = red;
         neg_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff[0]   <= fold_in;
         neg_ff[0] <= neg_in;
      end
   end

   assign x_st[0] = gcd_pkg::CORDIC_X0;
   assign y_st[0] = '0;

   // one micro-rotation per stage
   for (genvar i = 0; i < N; i++) begin : g_step
      gcd_pkg::xy_type  dx, dy, x_in, y_in;
      gcd_pkg::ang_type z_in;

      if (i > 0) begin : g_fwd
         assign x_st[i] = x_ff[i];
         assign y_st[i] = y_ff[i];
      end

      always_comb begin
         dx = x_st[i] >>> 0;
         dx = y_st[i] >>> i;
         dy = x_st[i] >>> i;
         if (z_ff[i] >= 0) begin
            x_in = x_st[i] - dx;
            y_in = y_st[i] + dy;
            z_in = z_ff[i] - gcd_pkg::ATAN_TAB[i];
         end else begin
            x_in = x_st[i] + dx;
            y_in = y_st[i] - dy;
            z_in = z_ff[i] + gcd_pkg::ATAN_TAB[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]   <= x_in;
            y_ff[i+1]   <= y_in;
            z_ff[i+1]   <= z_in;
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   assign x_st[N] = x_ff[N];
   assign y_st[N] = y_ff[N];

   // undo the half-turn fold
   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= neg_ff[N] ? gcd_pkg::q_type'(-y_st[N]) : gcd_pkg::q_type'(y_st[N]);
         cos_ff <= neg_ff[N] ? gcd_pkg::q_type'(-x_st[N]) : gcd_pkg::q_type'(x_st[N]);
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= N + 1; j++) begin
            vld_ff[j] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= vld_i;
         for (int j = 1; j <= N + 1; j++) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end
   end

   assign vld_o = vld_ff[N+1];
   assign sin_o = sin_ff;
   assign cos_o = cos_ff;

endmodule

[design/gcd_combine.sv]
// ----------------------------------------------------------------------------
// gcd_combine
// Law of cosines sum, clamp to [-1, 1], and 1 - c^2 for the square root.
// Multiplies in stages 1, 2 and 4.
// ----------------------------------------------------------------------------
module gcd_combine (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             vld_i,
   input  gcd_pkg::q_type   sa_i,
   input  gcd_pkg::q_type   ca_i,
   input  gcd_pkg::q_type   sb_i,
   input  gcd_pkg::q_type   cb_i,
   input  gcd_pkg::q_type   cd_i,
   output logic             vld_o,
   output gcd_pkg::rem_type rem_o,
   output gcd_pkg::q_type   c_o
);

   logic               vld_ff [0:4];
   gcd_pkg::prod_type  pss_ff, pss2_ff, pcc_ff, pccd_ff;
   gcd_pkg::q_type     cd_ff, c_ff, c2_ff, c3_ff;
   gcd_pkg::prod_type  csq_ff;
   gcd_pkg::rem_type   rem_ff;
   gcd_pkg::q_type     cc;
   gcd_pkg::prod_type  sum, sh;
   gcd_pkg::q_type     c_in;

   assign cc  = gcd_pkg::q_type'(pcc_ff >>> 30);
   assign sum = pss2_ff + pccd_ff + gcd_pkg::Q30_HALF;
   assign sh  = sum >>> 30;

   // clamp the combined cosine
   always_comb begin
      if (sh > gcd_pkg::prod_type'(gcd_pkg::Q30_ONE)) begin
         c_in = gcd_pkg::Q30_ONE;
      end else if (sh < -gcd_pkg::prod_type'(gcd_pkg::Q30_ONE)) begin
         c_in = -gcd_pkg::Q30_ONE;
      end else begin
         c_in = gcd_pkg::q_type'(sh);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: sin*sin, cos*cos
         pss_ff  <= gcd_pkg::prod_type'(sa_i) * gcd_pkg::prod_type'(sb_i);
         pcc_ff  <= gcd_pkg::prod_type'(ca_i) * gcd_pkg::prod_type'(cb_i);
         cd_ff   <= cd_i;
         // stage 2: times cos(dlon)
         pccd_ff <= gcd_pkg::prod_type'(cc) * gcd_pkg::prod_type'(cd_ff);
         pss2_ff <= pss_ff;
         // stage 3: round and clamp
         c_ff    <= c_in;
         // stage 4: square
         csq_ff  <= gcd_pkg::prod_type'(c_ff) * gcd_pkg::prod_type'(c_ff);
         c2_ff   <= c_ff;
         // stage 5: 1 - c^2 in Q60
         rem_ff  <= gcd_pkg::Q60_ONE - gcd_pkg::rem_type'(csq_ff);
         c3_ff   <= c2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 5; j++) begin
            vld_ff[j] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= vld_i;
         for (int j = 1; j < 5; j++) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end
   end

   assign vld_o = vld_ff[4];
   assign rem_o = rem_ff;
   assign c_o   = c3_ff;

endmodule

[design/gcd_isqrt.sv]
// ----------------------------------------------------------------------------
// gcd_isqrt
// Floor square root, one root bit per stage, restoring form.
// The cosine rides along for the arccos stage.
// ----------------------------------------------------------------------------
module gcd_isqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              vld_i,
   input  gcd_pkg::rem_type  rad_i,
   input  gcd_pkg::q_type    c_i,
   output logic              vld_o,
   output gcd_pkg::root_type root_o,
   output gcd_pkg::q_type    c_o
);

   localparam int N = gcd_pkg::ROOTW;

   logic              vld_ff [0:N-1];
   gcd_pkg::rem_type  rem_ff [0:N-1];
   gcd_pkg::root_type r_ff   [0:N-1];
   gcd_pkg::q_type    c_ff   [0:N-1];
   gcd_pkg::rem_type  rem_st [0:N-1];
   gcd_pkg::root_type r_st   [0:N-1];
   gcd_pkg::q_type    c_st   [0:N-1];

   assign rem_st[0] = rad_i;
   assign r_st[0]   = '0;
   assign c_st[0]   = c_i;

   // stage j decides root bit k = N-1-j
   for (genvar j = 0; j < N; j++) begin : g_bit
      localparam int K = N - 1 - j;
      gcd_pkg::trial_type trial;
      logic               take;

      if (j > 0) begin : g_fwd
         assign rem_st[j] = rem_ff[j-1];
         assign r_st[j]   = r_ff[j-1];
         assign c_st[j]   = c_ff[j-1];
      end

      // (r + 2^k)^2 - r^2 ; low bits of r are still zero
      assign trial = (gcd_pkg::trial_type'(r_st[j]) << (K + 1))
                   | (gcd_pkg::trial_type'(1) << (2 * K));
      assign take  = gcd_pkg::trial_type'(rem_st[j]) >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= take ? gcd_pkg::rem_type'(gcd_pkg::trial_type'(rem_st[j]) - trial)
                              : rem_st[j];
            r_ff[j]   <= take ? (r_st[j] | (gcd_pkg::root_type'(1) << K)) : r_st[j];
            c_ff[j]   <= c_st[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < N; j++) begin
            vld_ff[j] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= vld_i;
         for (int j = 1; j < N; j++) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end
   end

   assign vld_o  = vld_ff[N-1];
   assign root_o = r_ff[N-1];
   assign c_o    = c_ff[N-1];

endmodule

[design/gcd_acos.sv]
// ----------------------------------------------------------------------------
// gcd_acos
// Arccos as atan2(sqrt(1-c^2), c) by pipelined vectoring CORDIC, then
// clamp to [0, 180] degrees and scale by 15.
// ----------------------------------------------------------------------------
module gcd_acos (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              vld_i,
   input  gcd_pkg::root_type s_i,
   input  gcd_pkg::q_type    c_i,
   output logic              vld_o,
   output gcd_pkg::t_type    ang15_o
);

   localparam int N = gcd_pkg::STEPS;

   logic             vld_ff [0:N+1];
   gcd_pkg::xy_type  x_ff   [0:N];
   gcd_pkg::xy_type  y_ff   [0:N];
   gcd_pkg::ang_type z_ff   [0:N];
   gcd_pkg::t_type   t_ff;
   gcd_pkg::zc_type  zc;

   // start vector, negative cosine turned by 90 degrees
   always_ff @(posedge clock) begin
      if (en) begin
         if (c_i < 0) begin
            x_ff[0] <= gcd_pkg::xy_type'(s_i);
            y_ff[0] <= -gcd_pkg::xy_type'(c_i);
            z_ff[0] <= gcd_pkg::ANG_QUARTER;
         end else begin
            x_ff[0] <= gcd_pkg::xy_type'(c_i);
            y_ff[0] <= gcd_pkg::xy_type'(s_i);
            z_ff[0] <= '0;
         end
      end
   end

   // one vectoring step per stage
   for (genvar i = 0; i < N; i++) begin : g_step
      gcd_pkg::xy_type dx, dy;

      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + gcd_pkg::ATAN_TAB[i];
            end else begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - gcd_pkg::ATAN_TAB[i];
            end
         end
      end
   end

   // clamp to [0, 180 deg]
   always_comb begin
      if (z_ff[N] < 0) begin
         zc = '0;
      end else if (z_ff[N] > gcd_pkg::ANG_HALF) begin
         zc = gcd_pkg::zc_type'(gcd_pkg::ANG_HALF);
      end else begin
         zc = gcd_pkg::zc_type'(z_ff[N]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff <= (gcd_pkg::t_type'(zc) << 4) - gcd_pkg::t_type'(zc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= N + 1; j++) begin
            vld_ff[j] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= vld_i;
         for (int j = 1; j <= N + 1; j++) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end
   end

   assign vld_o   = vld_ff[N+1];
   assign ang15_o = t_ff;

endmodule

[design/great_circle_distance_core.sv]
// Order: input register, rotate, combine, isqrt, acos, output register.
// Throughput: one point pair per cycle; a stalled response holds the
// whole pipeline in place, set by the single shared stage enable.
// Reset: synchronous, clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// great_circle_distance_core
// Great circle distance by the spherical law of cosines, fully pipelined:
// three sin/cos CORDICs, products, square root, arccos CORDIC, scaling.
// ----------------------------------------------------------------------------
module great_circle_distance_core (
   input  logic   clock,
   input  logic   reset,
   gcd_req_if.sink    req,
   gcd_rsp_if.source  rsp
);

   logic                     en;
   logic                     in_vld_ff;
   gcd_pkg::ang_type         lat_a_ff, lat_b_ff, dlon_ff;
   gcd_pkg::ang_type         dlon_in;

   logic                     rot_vld;
   gcd_pkg::q_type           sa, ca, sb, cb, sd, cd;
   logic                     cmb_vld;
   gcd_pkg::rem_type         rad;
   gcd_pkg::q_type           c_cmb, c_sq;
   logic                     sq_vld;
   gcd_pkg::root_type        root;
   logic                     ac_vld;
   gcd_pkg::t_type           ang15;
   gcd_pkg::tr_type          rnd;

   logic                     rsp_valid_ff;
   logic [gcd_pkg::DISTW-1:0] dist_ff;

   // pipeline advances unless the output holds an untaken result
   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   assign dlon_in = (gcd_pkg::ang_type'(req.lon_a) - gcd_pkg::ang_type'(req.lon_b)) <<< 8;

   // input stage: scale to 2^-24 degree
   always_ff @(posedge clock) begin
      if (en) begin
         lat_a_ff <= gcd_pkg::ang_type'(req.lat_a) <<< 8;
         lat_b_ff <= gcd_pkg::ang_type'(req.lat_b) <<< 8;
         dlon_ff  <= dlon_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (en) begin
         in_vld_ff <= req.valid;
      end
   end

   gcd_rotate u_rot_a (
      .clock (clock), .reset (reset), .en (en), .vld_i (in_vld_ff),
      .ang_i (lat_a_ff), .vld_o (rot_vld), .sin_o (sa), .cos_o (ca)
   );

   gcd_rotate u_rot_b (
      .clock (clock), .reset (reset), .en (en), .vld_i (in_vld_ff),
      .ang_i (lat_b_ff), .vld_o (), .sin_o (sb), .cos_o (cb)
   );

   gcd_rotate u_rot_d (
      .clock (clock), .reset (reset), .en (en), .vld_i (in_vld_ff),
      .ang_i (dlon_ff), .vld_o (), .sin_o (sd), .cos_o (cd)
   );

   gcd_combine u_combine (
      .clock (clock), .reset (reset), .en (en), .vld_i (rot_vld),
      .sa_i (sa), .ca_i (ca), .sb_i (sb), .cb_i (cb), .cd_i (cd),
      .vld_o (cmb_vld), .rem_o (rad), .c_o (c_cmb)
   );

   gcd_isqrt u_isqrt (
      .clock (clock), .reset (reset), .en (en), .vld_i (cmb_vld),
      .rad_i (rad), .c_i (c_cmb), .vld_o (sq_vld), .root_o (root), .c_o (c_sq)
   );

   gcd_acos u_acos (
      .clock (clock), .reset (reset), .en (en), .vld_i (sq_vld),
      .s_i (root), .c_i (c_sq), .vld_o (ac_vld), .ang15_o (ang15)
   );

   // output register: round to NM * 256
   assign rnd = gcd_pkg::tr_type'(ang15) + gcd_pkg::OUT_RND;

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= rnd[14 +: gcd_pkg::DISTW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ac_vld;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.distance_nm = dist_ff;

   // unused sine of the longitude difference
   logic sd_unused;
   assign sd_unused = ^sd;

`ifndef NO_ASSERTIONS
   // an empty output stage never blocks new requests
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req.ready)
      else $error("request blocked with empty output stage");

   // distance never exceeds half the circumference
   a_dist_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> dist_ff <= 22'd2764800)
      else $error("distance out of range");

   // nothing comes out right after reset
   a_reset_clears : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("response valid after reset");

   // a stall freezes the output stage's valid
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !en |=> rsp_valid_ff)
      else $error("result lost during stall");
`endif

endmodule
